/* hdl/text_console_writer_core_macros.svh */
// Assertion macros for the text console writer.
// Included by modules that check their own sequencing; needs nothing else.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// Used by the top level; depends on nothing.
package tcw_pkg;

	// Default geometry of the console.
	localparam int DEF_COLUMNS   = 80;
	localparam int DEF_ROWS      = 25;
	localparam int DEF_TAB_WIDTH = 4;

	// Field widths of the request and result ports.
	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int PROW_W   = 5;
	localparam int PCOL_W   = 7;
	localparam int CELL_W   = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_ERASE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Character codes with a special meaning.
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NONE      = 8'h00;

	// Cell value after reset and attribute register reset value.
	localparam logic [CELL_W-1:0] RESET_CELL = 16'h0700;
	localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CLEAR  = 5'b00010,
		ST_WRITE  = 5'b00100,
		ST_READ   = 5'b01000,
		ST_SCROLL = 5'b10000
	} tcw_state_t;

endpackage

/* hdl/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
module tcw_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/text_console_writer_core.sv */
// Top level of the text console writer: cursor, sequencer and the cell store.
// Depends on tcw_pkg, tcw_ram and text_console_writer_core_macros.svh.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start / busy       | operation, char_code, read_row, read_col
//  result    | done (one cycle)   | cursor_row, cursor_col, read_cell
//  attribute | attr_we            | attr_wdata
//
// A put, erase or read passes through the write or read state between
// acceptance and done; an unused operation code (3) raises done straight
// after acceptance. A put that moves past the last row scrolls first: every
// cell is rewritten, copied from the row below through the single RAM read
// port. After reset the store is cleared one cell per cycle, with busy high.
// Results cannot be stalled; done pulses once per request.
`include "text_console_writer_core_macros.svh"

module text_console_writer_core #(
	parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tcw_pkg::DEF_ROWS,
	parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tcw_pkg::OP_W-1:0]    operation,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::PROW_W-1:0]  read_row,
	input  logic [tcw_pkg::PCOL_W-1:0]  read_col,
	input  logic                        attr_we,
	input  logic [tcw_pkg::CHAR_W-1:0]  attr_wdata,
	output logic                        done,
	output logic [tcw_pkg::PROW_W-1:0]  cursor_row,
	output logic [tcw_pkg::PCOL_W-1:0]  cursor_col,
	output logic [tcw_pkg::CELL_W-1:0]  read_cell
);

	import tcw_pkg::*;

	localparam int TOTAL       = ROWS * COLUMNS;
	localparam int COPY_CELLS  = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W      = $clog2(TOTAL);
	localparam int CNT_W       = $clog2(TOTAL + 1);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int COL_W       = $clog2(COLUMNS);
	localparam int CX_W        = $clog2(COLUMNS + TAB_WIDTH + 1);
	localparam int TM_W        = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int LAST_PHASE  = (COLUMNS - 1) % TAB_WIDTH;

	tcw_state_t          state_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [TM_W-1:0]     tab_ph_q;
	logic [CHAR_W-1:0]   attr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                wr_vld_s1;
	logic [ADDR_W-1:0]   wr_addr_s1;
	logic                wr_copy_s1;
	logic [CELL_W-1:0]   wdata_q;
	logic                rd_ok_q;
	logic                done_q;
	logic [CELL_W-1:0]   read_cell_q;

	logic                accept;
	logic [ADDR_W-1:0]   cur_addr;
	logic                rd_in_range;
	logic [ROW_W-1:0]    nxt_row;
	logic [COL_W-1:0]    nxt_col;
	logic [TM_W-1:0]     nxt_ph;
	logic                nxt_scroll;
	logic                char_wr;
	logic                go_next;
	logic [CX_W-1:0]     tab_col;
	logic [CX_W-1:0]     inc_col;

	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [CELL_W-1:0]   ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [CELL_W-1:0]   ram_rd_data;

	// Handshake and result ports.
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign cursor_row = PROW_W'(cur_row_q);
	assign cursor_col = PCOL_W'(cur_col_q);
	assign read_cell  = read_cell_q;

	// Linear cell address of the cursor and range check of a read request.
	assign cur_addr    = ADDR_W'(32'(cur_row_q) * COLUMNS + 32'(cur_col_q));
	assign rd_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);

	// Candidate columns for a tab stop and for a plain advance.
	assign tab_col = CX_W'(cur_col_q) - CX_W'(tab_ph_q) + CX_W'(TAB_WIDTH);
	assign inc_col = CX_W'(cur_col_q) + CX_W'(1);

	// Cursor movement of the request on the ports.
	always_comb begin
		nxt_row    = cur_row_q;
		nxt_col    = cur_col_q;
		nxt_ph     = tab_ph_q;
		nxt_scroll = 1'b0;
		char_wr    = 1'b0;
		go_next    = 1'b0;
		unique case (operation)
			OP_PUT: begin
				if (char_code == CH_NEWLINE) begin
					go_next = 1'b1;
				end else if (char_code == CH_TAB) begin
					if (tab_col >= CX_W'(COLUMNS)) begin
						go_next = 1'b1;
					end else begin
						nxt_col = COL_W'(tab_col);
						nxt_ph  = '0;
					end
				end else if (char_code != CH_BACKSPACE) begin
					char_wr = 1'b1;
					if (inc_col >= CX_W'(COLUMNS)) begin
						go_next = 1'b1;
					end else begin
						nxt_col = COL_W'(inc_col);
						nxt_ph  = (tab_ph_q == TM_W'(TAB_WIDTH - 1)) ? '0 : tab_ph_q + 1'b1;
					end
				end
			end
			OP_ERASE: begin
				if (cur_col_q != '0) begin
					nxt_col = cur_col_q - 1'b1;
					nxt_ph  = (tab_ph_q == '0) ? TM_W'(TAB_WIDTH - 1) : tab_ph_q - 1'b1;
				end else if (cur_row_q != '0) begin
					nxt_row = cur_row_q - 1'b1;
					nxt_col = COL_W'(COLUMNS - 1);
					nxt_ph  = TM_W'(LAST_PHASE);
				end
			end
			default: begin
				nxt_row = cur_row_q;
			end
		endcase
		// Moving to the next row scrolls when the cursor is on the last one.
		if (go_next) begin
			nxt_col = '0;
			nxt_ph  = '0;
			if (cur_row_q == ROW_W'(ROWS - 1)) begin
				nxt_scroll = 1'b1;
			end else begin
				nxt_row = cur_row_q + 1'b1;
			end
		end
	end

	// Write port: clear pass, scroll copy, final cell write or a character.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = cur_addr;
		ram_wr_data = {attr_q, char_code};
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = cnt_q[ADDR_W-1:0];
				ram_wr_data = RESET_CELL;
			end
			ST_SCROLL: begin
				ram_wr_en   = wr_vld_s1;
				ram_wr_addr = wr_addr_s1;
				ram_wr_data = wr_copy_s1 ? ram_rd_data : '0;
			end
			ST_WRITE: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = wdata_q;
			end
			ST_IDLE: begin
				ram_wr_en = accept && (operation == OP_PUT) && char_wr;
			end
			ST_READ: begin
				ram_wr_en = 1'b0;
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	// Read port: a read request, or the row below during a scroll.
	always_comb begin
		if (state_q == ST_SCROLL) begin
			ram_rd_en   = (32'(cnt_q) < COPY_CELLS);
			ram_rd_addr = ADDR_W'(32'(cnt_q) + COLUMNS);
		end else begin
			ram_rd_en   = accept && (operation == OP_READ) && rd_in_range;
			ram_rd_addr = ADDR_W'(32'(read_row) * COLUMNS + 32'(read_col));
		end
	end

	tcw_ram #(
		.DATA_W (CELL_W),
		.DEPTH  (TOTAL),
		.ADDR_W (ADDR_W)
	) u_cells (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (attr_we) begin
			attr_q <= attr_wdata;
		end
	end

	// Payload registers: pending cell value and read result.
	always_ff @(posedge clk) begin
		if (accept) begin
			wdata_q     <= {attr_q, (operation == OP_PUT) ? CH_SPACE : CH_NONE};
			rd_ok_q     <= rd_in_range;
			read_cell_q <= '0;
		end else if (state_q == ST_READ) begin
			read_cell_q <= rd_ok_q ? ram_rd_data : '0;
		end
		wr_addr_s1 <= cnt_q[ADDR_W-1:0];
		wr_copy_s1 <= (32'(cnt_q) < COPY_CELLS);
	end

	// Result strobe: after the final write or the read, or right after an unused operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WRITE) || (state_q == ST_READ) ||
				(accept && (operation != OP_PUT) && (operation != OP_ERASE) &&
				(operation != OP_READ));
		end
	end

	// Sequencer, cursor and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cur_row_q <= '0;
			cur_col_q <= '0;
			tab_ph_q  <= '0;
			cnt_q     <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CNT_W'(TOTAL - 1)) begin
						state_q <= ST_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							OP_PUT, OP_ERASE: begin
								cur_row_q <= nxt_row;
								cur_col_q <= nxt_col;
								tab_ph_q  <= nxt_ph;
								cnt_q     <= '0;
								state_q   <= nxt_scroll ? ST_SCROLL : ST_WRITE;
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCROLL: begin
					// Read one cell ahead, write it a row higher in the next cycle.
					if (32'(cnt_q) < TOTAL) begin
						wr_vld_s1 <= 1'b1;
						cnt_q     <= cnt_q + 1'b1;
					end else begin
						wr_vld_s1 <= 1'b0;
						state_q   <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencing.
	`TCW_ASSERT_SAME(a_done_idle, clk, arst_n, done_q, state_q == ST_IDLE, "result while busy")
	`TCW_ASSERT_NEXT(a_cursor_hold, clk, arst_n, busy, $stable(cur_row_q) && $stable(cur_col_q), "cursor moved while busy")
	`TCW_ASSERT_SAME(a_scroll_cursor, clk, arst_n, state_q == ST_SCROLL, (cur_row_q == ROW_W'(ROWS - 1)) && (cur_col_q == '0), "scroll with cursor off the last row start")
	`TCW_ASSERT_SAME(a_scroll_ports, clk, arst_n, (state_q == ST_SCROLL) && wr_vld_s1 && ram_rd_en, ram_rd_addr != wr_addr_s1, "scroll read and write hit one cell")

endmodule
